### hw/rtl/fct_pkg.sv
// ----------------------------------------------------------------------------
// fct_pkg
// Shared types, codes and constants of the flow cache with timeouts.
// ----------------------------------------------------------------------------
package fct_pkg;

    localparam int FC_ENTRIES  = 1024;
    localparam int ACT_W       = 6;
    localparam int INACT_W     = 10;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 10;
    localparam int IN_DATA_W   = 160;
    localparam int OUT_DATA_W  = 240;
    localparam int SEC_PER_MIN = 60;
    localparam int ACT_MUL_W   = 12;

    localparam logic [ACT_W-1:0]   ACT_RESET   = ACT_W'(30);
    localparam logic [INACT_W-1:0] INACT_RESET = INACT_W'(15);

    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INACTIVE = 2'd1;

    localparam logic CMD_PACKET = 1'b0;
    localparam logic CMD_TICK   = 1'b1;

    localparam logic [2:0] KIND_HIT   = 3'd0;
    localparam logic [2:0] KIND_NEW   = 3'd1;
    localparam logic [2:0] KIND_DROP  = 3'd2;
    localparam logic [2:0] KIND_INACT = 3'd3;
    localparam logic [2:0] KIND_ACT   = 3'd4;

    localparam logic [3:0] OP_NONE      = 4'd0;
    localparam logic [3:0] OP_LOAD      = 4'd1;
    localparam logic [3:0] OP_SCAN_RD   = 4'd2;
    localparam logic [3:0] OP_SCAN_NEXT = 4'd3;
    localparam logic [3:0] OP_HIT_A     = 4'd4;
    localparam logic [3:0] OP_HIT_B     = 4'd5;
    localparam logic [3:0] OP_HIT_C     = 4'd6;
    localparam logic [3:0] OP_ALLOC_RD  = 4'd7;
    localparam logic [3:0] OP_ALLOC     = 4'd8;
    localparam logic [3:0] OP_LINK      = 4'd9;
    localparam logic [3:0] OP_DROP      = 4'd10;
    localparam logic [3:0] OP_EXP_INACT = 4'd11;
    localparam logic [3:0] OP_TICK_RD2  = 4'd12;
    localparam logic [3:0] OP_EXP_ACT   = 4'd13;
    localparam logic [3:0] OP_EMIT_HOLD = 4'd14;
    localparam logic [3:0] OP_EMIT_REC  = 4'd15;

    typedef struct packed {
        logic [31:0] src;
        logic [31:0] dst;
        logic [15:0] sport;
        logic [15:0] dport;
        logic [7:0]  proto;
    } t_key;

    typedef struct packed {
        logic [7:0]  flags;
        logic [31:0] pkts;
        logic [31:0] octs;
        logic [31:0] first;
        logic [31:0] last;
    } t_ent;

    typedef struct packed {
        logic [2:0] kind;
        t_key       key;
        t_ent       ent;
    } t_rec;

    typedef struct packed {
        logic [3:0] op;
        logic       last;
    } t_cmd;

    typedef struct packed {
        logic match;
        logic cur_zero;
        logic full;
        logic inact_exp;
        logic act_exp;
        logic out_free;
    } t_sts;

endpackage

### hw/rtl/flow_cache_with_timeouts_unit.sv
// ----------------------------------------------------------------------------
// flow_cache_with_timeouts_unit
// Five-tuple flow cache with recency and creation lists, active and
// inactive timeout expiry, one item at a time.
// ----------------------------------------------------------------------------
// One item is worked on at a time. A packet is first taken in and then
// walks the recency list from its oldest flow, reading each flow and then
// comparing it, because the key and link tables share one registered read
// address; a hit, a new flow or a drop then has its record loaded into the
// output register. Each record waits in the output register until taken,
// which holds the sequencer while a stalled record is still there, and a
// tick that expires two flows shows the inactive record first. After reset
// the tables need no clearing: unused entries are handed out from a fill
// counter, freed ones from a linked stack.
// ----------------------------------------------------------------------------
module flow_cache_with_timeouts_unit #(
    parameter int ENTRIES = fct_pkg::FC_ENTRIES
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // source address, destination address, source port, destination port,
    // protocol, tcp flag bits, packet length, time in seconds
    input  logic [fct_pkg::IN_DATA_W-1:0]    i_s_tdata,
    input  logic                             i_s_tuser,    // command
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    // source address, destination address, source port, destination port,
    // protocol, accumulated flags, packet total, octet total, first seen,
    // last seen
    output logic [fct_pkg::OUT_DATA_W-1:0]   o_m_tdata,
    output logic [2:0]                       o_m_tuser,    // kind
    output logic                             o_m_tlast,    // final_res
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [fct_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [fct_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import fct_pkg::*;

    t_cmd cmd;
    t_sts sts;
    t_rec out_rec;

    fct_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_tvalid),
        .i_in_cmd   (i_s_tuser),
        .o_in_ready (o_s_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    fct_dp #(
        .ENTRIES (ENTRIES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_in_data   (i_s_tdata),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_m_tvalid),
        .i_out_ready (i_m_tready),
        .o_out_rec   (out_rec),
        .o_out_last  (o_m_tlast)
    );

    assign o_cfg_ready = 1'b1;
    assign o_m_tuser   = out_rec.kind;
    assign o_m_tdata   = {out_rec.ent.last, out_rec.ent.first, out_rec.ent.octs,
                          out_rec.ent.pkts, out_rec.ent.flags, out_rec.key.proto,
                          out_rec.key.dport, out_rec.key.sport, out_rec.key.dst,
                          out_rec.key.src};

endmodule

### hw/rtl/fct_ctrl.sv
// ----------------------------------------------------------------------------
// fct_ctrl
// Sequencer of the flow cache: walks lookup, update, allocation, expiry
// and record output one step per cycle, holding while a record waits on the output.
// ----------------------------------------------------------------------------
module fct_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_in_cmd,
    output logic          o_in_ready,
    input  fct_pkg::t_sts i_sts,
    output fct_pkg::t_cmd o_cmd
);
    import fct_pkg::*;

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_SCAN_CHK = 4'd1;
    localparam logic [3:0] ST_SCAN_CMP = 4'd2;
    localparam logic [3:0] ST_HIT_B    = 4'd3;
    localparam logic [3:0] ST_HIT_C    = 4'd4;
    localparam logic [3:0] ST_MISS     = 4'd5;
    localparam logic [3:0] ST_ALLOC    = 4'd6;
    localparam logic [3:0] ST_LINK     = 4'd7;
    localparam logic [3:0] ST_EMIT     = 4'd8;
    localparam logic [3:0] ST_T_CMP1   = 4'd9;
    localparam logic [3:0] ST_T_RD2    = 4'd10;
    localparam logic [3:0] ST_T_CMP2   = 4'd11;
    localparam logic [3:0] ST_T_EMIT1  = 4'd12;
    localparam logic [3:0] ST_T_EMIT2  = 4'd13;

    logic [3:0] r_state, n_state;
    logic       r_exp1, n_exp1;
    logic       r_exp2, n_exp2;

    assign o_in_ready = (r_state == ST_IDLE);

    always_comb begin
        n_state   = r_state;
        n_exp1    = r_exp1;
        n_exp2    = r_exp2;
        o_cmd.op   = OP_NONE;
        o_cmd.last = 1'b1;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = OP_LOAD;
                    n_state  = (i_in_cmd == CMD_TICK) ? ST_T_CMP1 : ST_SCAN_CHK;
                end
            end
            ST_SCAN_CHK: begin
                if (i_sts.cur_zero) begin
                    n_state = ST_MISS;
                end else begin
                    o_cmd.op = OP_SCAN_RD;
                    n_state  = ST_SCAN_CMP;
                end
            end
            ST_SCAN_CMP: begin
                if (i_sts.match) begin
                    o_cmd.op = OP_HIT_A;
                    n_state  = ST_HIT_B;
                end else begin
                    o_cmd.op = OP_SCAN_NEXT;
                    n_state  = ST_SCAN_CHK;
                end
            end
            ST_HIT_B: begin
                o_cmd.op = OP_HIT_B;
                n_state  = ST_HIT_C;
            end
            ST_HIT_C: begin
                o_cmd.op = OP_HIT_C;
                n_state  = ST_EMIT;
            end
            ST_MISS: begin
                if (i_sts.full) begin
                    o_cmd.op = OP_DROP;
                    n_state  = ST_EMIT;
                end else begin
                    o_cmd.op = OP_ALLOC_RD;
                    n_state  = ST_ALLOC;
                end
            end
            ST_ALLOC: begin
                o_cmd.op = OP_ALLOC;
                n_state  = ST_LINK;
            end
            ST_LINK: begin
                o_cmd.op = OP_LINK;
                n_state  = ST_EMIT;
            end
            ST_EMIT: begin
                o_cmd.op = OP_EMIT_REC;
                if (i_sts.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            ST_T_CMP1: begin
                n_exp1 = i_sts.inact_exp;
                if (i_sts.inact_exp) begin
                    o_cmd.op = OP_EXP_INACT;
                end
                n_state = ST_T_RD2;
            end
            ST_T_RD2: begin
                o_cmd.op = OP_TICK_RD2;
                n_state  = ST_T_CMP2;
            end
            ST_T_CMP2: begin
                n_exp2 = i_sts.act_exp;
                if (i_sts.act_exp) begin
                    o_cmd.op = OP_EXP_ACT;
                end
                n_state = ST_T_EMIT1;
            end
            ST_T_EMIT1: begin
                if (r_exp1) begin
                    o_cmd.op   = OP_EMIT_HOLD;
                    o_cmd.last = !r_exp2;
                    if (i_sts.out_free) begin
                        n_state = ST_T_EMIT2;
                    end
                end else begin
                    n_state = ST_T_EMIT2;
                end
            end
            ST_T_EMIT2: begin
                if (r_exp2) begin
                    o_cmd.op = OP_EMIT_REC;
                    if (i_sts.out_free) begin
                        n_state = ST_IDLE;
                    end
                end else begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_exp1  <= 1'b0;
            r_exp2  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_exp1  <= n_exp1;
            r_exp2  <= n_exp2;
        end
    end

endmodule

### hw/rtl/fct_dp.sv
// ----------------------------------------------------------------------------
// fct_dp
// Datapath of the flow cache: entry tables, list pointers, free list,
// timeout compares, configuration registers and the output register.
// ----------------------------------------------------------------------------
module fct_dp #(
    parameter int ENTRIES = fct_pkg::FC_ENTRIES
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  fct_pkg::t_cmd                   i_cmd,
    output fct_pkg::t_sts                   o_sts,
    input  logic [fct_pkg::IN_DATA_W-1:0]   i_in_data,
    input  logic                            i_cfg_valid,
    input  logic [fct_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [fct_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output fct_pkg::t_rec                   o_out_rec,
    output logic                            o_out_last
);
    import fct_pkg::*;

    localparam int IW = $clog2(ENTRIES);

    // entry tables, one write and one registered read per cycle each
    t_key           m_key   [ENTRIES];
    t_ent           m_ent   [ENTRIES];
    logic [IW-1:0]  m_rnext [ENTRIES];
    logic [IW-1:0]  m_rprev [ENTRIES];
    logic [IW-1:0]  m_cnext [ENTRIES];
    logic [IW-1:0]  m_cprev [ENTRIES];
    logic [IW-1:0]  m_free  [ENTRIES];

    t_key          key_rd;
    t_ent          ent_rd;
    logic [IW-1:0] rn_rd, rp_rd, cn_rd, cp_rd, fr_rd;

    logic          key_we, ent_we, rn_we, rp_we, cn_we, cp_we, fr_we;
    logic [IW-1:0] key_wa, ent_wa, rn_wa, rp_wa, cn_wa, cp_wa, fr_wa;
    t_key          key_wd;
    t_ent          ent_wd;
    logic [IW-1:0] rn_wd, rp_wd, cn_wd, cp_wd, fr_wd;
    logic [IW-1:0] rd_addr;

    // latched item
    t_key        r_key;
    logic [7:0]  r_flags;
    logic [15:0] r_len;
    logic [31:0] r_now;

    logic [IW-1:0] r_rdaddr;
    logic [IW-1:0] r_cur, n_cur;
    logic [IW-1:0] r_h, n_h;
    logic [IW-1:0] r_p, n_p;
    logic [IW-1:0] r_p2, n_p2;
    logic [IW-1:0] r_rhead, n_rhead, r_rtail, n_rtail;
    logic [IW-1:0] r_chead, n_chead, r_ctail, n_ctail;
    logic [IW-1:0] r_rec_head, n_rec_head;
    logic [IW:0]   r_fresh, n_fresh;
    t_rec          r_rec, n_rec, r_hold, n_hold;

    logic [ACT_W-1:0]   r_act;
    logic [INACT_W-1:0] r_inact;

    logic                 r_ovalid;
    t_rec                 r_out;
    logic                 r_olast;

    t_ent          upd_ent, new_ent;
    logic [IW-1:0] alloc_idx;
    logic          do_exp;
    logic          emit;
    logic          out_free;
    logic [ACT_MUL_W-1:0] act_secs;

    assign upd_ent.flags = ent_rd.flags | r_flags;
    assign upd_ent.pkts  = ent_rd.pkts + 32'd1;
    assign upd_ent.octs  = ent_rd.octs + 32'(r_len);
    assign upd_ent.first = ent_rd.first;
    assign upd_ent.last  = r_now;

    assign new_ent.flags = r_flags;
    assign new_ent.pkts  = 32'd1;
    assign new_ent.octs  = 32'(r_len);
    assign new_ent.first = r_now;
    assign new_ent.last  = r_now;

    assign alloc_idx = (r_rec_head != '0) ? r_rec_head : r_fresh[IW-1:0];
    assign act_secs  = ACT_MUL_W'(r_act) * ACT_MUL_W'(SEC_PER_MIN);
    assign out_free  = !r_ovalid || i_out_ready;
    assign emit      = (i_cmd.op == OP_EMIT_HOLD) || (i_cmd.op == OP_EMIT_REC);

    assign o_sts.match     = (key_rd == r_key);
    assign o_sts.cur_zero  = (r_cur == '0);
    assign o_sts.full      = (r_rec_head == '0) && (r_fresh == (IW+1)'(ENTRIES));
    assign o_sts.inact_exp = (r_rdaddr != '0) &&
        (({1'b0, ent_rd.last} + 33'(r_inact)) < {1'b0, r_now});
    assign o_sts.act_exp   = (r_rdaddr != '0) &&
        (({1'b0, ent_rd.first} + 33'(act_secs)) < {1'b0, r_now});
    assign o_sts.out_free  = out_free;

    always_comb begin
        rd_addr    = r_rdaddr;
        n_cur      = r_cur;
        n_h        = r_h;
        n_p        = r_p;
        n_p2       = r_p2;
        n_rhead    = r_rhead;
        n_rtail    = r_rtail;
        n_chead    = r_chead;
        n_ctail    = r_ctail;
        n_rec_head = r_rec_head;
        n_fresh    = r_fresh;
        n_rec      = r_rec;
        n_hold     = r_hold;
        do_exp     = 1'b0;
        key_we = 1'b0; key_wa = alloc_idx; key_wd = r_key;
        ent_we = 1'b0; ent_wa = alloc_idx; ent_wd = new_ent;
        rn_we  = 1'b0; rn_wa  = '0; rn_wd = '0;
        rp_we  = 1'b0; rp_wa  = '0; rp_wd = '0;
        cn_we  = 1'b0; cn_wa  = '0; cn_wd = '0;
        cp_we  = 1'b0; cp_wa  = '0; cp_wd = '0;
        fr_we  = 1'b0; fr_wa  = r_rdaddr; fr_wd = r_rec_head;
        case (i_cmd.op)
            OP_LOAD: begin
                rd_addr = r_rhead;
                n_cur   = r_rhead;
            end
            OP_SCAN_RD: begin
                rd_addr = r_cur;
            end
            OP_SCAN_NEXT: begin
                n_cur = rn_rd;
            end
            OP_HIT_A: begin
                n_h       = r_rdaddr;
                ent_we    = 1'b1;
                ent_wa    = r_rdaddr;
                ent_wd    = upd_ent;
                n_rec.kind = KIND_HIT;
                n_rec.key  = key_rd;
                n_rec.ent  = upd_ent;
                // unlink from the recency list
                if (rp_rd == '0) begin
                    n_rhead = rn_rd;
                end else begin
                    rn_we = 1'b1; rn_wa = rp_rd; rn_wd = rn_rd;
                end
                if (rn_rd == '0) begin
                    n_rtail = rp_rd;
                end else begin
                    rp_we = 1'b1; rp_wa = rn_rd; rp_wd = rp_rd;
                end
            end
            OP_HIT_B: begin
                rn_we   = 1'b1; rn_wa = r_h; rn_wd = '0;
                rp_we   = 1'b1; rp_wa = r_h; rp_wd = r_rtail;
                n_p2    = r_rtail;
                n_rtail = r_h;
            end
            OP_HIT_C: begin
                if (r_p2 == '0) begin
                    n_rhead = r_h;
                end else begin
                    rn_we = 1'b1; rn_wa = r_p2; rn_wd = r_h;
                end
            end
            OP_ALLOC_RD: begin
                rd_addr = r_rec_head;
            end
            OP_ALLOC: begin
                n_h = alloc_idx;
                if (r_rec_head != '0) begin
                    n_rec_head = fr_rd;
                end else begin
                    n_fresh = r_fresh + (IW+1)'(1);
                end
                key_we = 1'b1;
                ent_we = 1'b1;
                cp_we  = 1'b1; cp_wa = alloc_idx; cp_wd = r_ctail;
                cn_we  = 1'b1; cn_wa = alloc_idx; cn_wd = '0;
                rp_we  = 1'b1; rp_wa = alloc_idx; rp_wd = r_rtail;
                rn_we  = 1'b1; rn_wa = alloc_idx; rn_wd = '0;
                n_p     = r_ctail;
                n_p2    = r_rtail;
                n_ctail = alloc_idx;
                n_rtail = alloc_idx;
                n_rec.kind = KIND_NEW;
                n_rec.key  = r_key;
                n_rec.ent  = new_ent;
            end
            OP_LINK: begin
                if (r_p == '0) begin
                    n_chead = r_h;
                end else begin
                    cn_we = 1'b1; cn_wa = r_p; cn_wd = r_h;
                end
                if (r_p2 == '0) begin
                    n_rhead = r_h;
                end else begin
                    rn_we = 1'b1; rn_wa = r_p2; rn_wd = r_h;
                end
            end
            OP_DROP: begin
                n_rec.kind = KIND_DROP;
                n_rec.key  = r_key;
                n_rec.ent  = '0;
            end
            OP_EXP_INACT: begin
                n_hold.kind = KIND_INACT;
                n_hold.key  = key_rd;
                n_hold.ent  = ent_rd;
                do_exp      = 1'b1;
            end
            OP_TICK_RD2: begin
                rd_addr = r_chead;
            end
            OP_EXP_ACT: begin
                n_rec.kind = KIND_ACT;
                n_rec.key  = key_rd;
                n_rec.ent  = ent_rd;
                do_exp     = 1'b1;
            end
            default: begin
            end
        endcase

        // unlink the read entry from both lists and push it on the free list
        if (do_exp) begin
            if (rp_rd == '0) begin
                n_rhead = rn_rd;
            end else begin
                rn_we = 1'b1; rn_wa = rp_rd; rn_wd = rn_rd;
            end
            if (rn_rd == '0) begin
                n_rtail = rp_rd;
            end else begin
                rp_we = 1'b1; rp_wa = rn_rd; rp_wd = rp_rd;
            end
            if (cp_rd == '0) begin
                n_chead = cn_rd;
            end else begin
                cn_we = 1'b1; cn_wa = cp_rd; cn_wd = cn_rd;
            end
            if (cn_rd == '0) begin
                n_ctail = cp_rd;
            end else begin
                cp_we = 1'b1; cp_wa = cn_rd; cp_wd = cp_rd;
            end
            fr_we      = 1'b1;
            n_rec_head = r_rdaddr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (key_we) begin
            m_key[key_wa] <= key_wd;
        end
        key_rd <= m_key[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (ent_we) begin
            m_ent[ent_wa] <= ent_wd;
        end
        ent_rd <= m_ent[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (rn_we) begin
            m_rnext[rn_wa] <= rn_wd;
        end
        rn_rd <= m_rnext[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (rp_we) begin
            m_rprev[rp_wa] <= rp_wd;
        end
        rp_rd <= m_rprev[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (cn_we) begin
            m_cnext[cn_wa] <= cn_wd;
        end
        cn_rd <= m_cnext[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (cp_we) begin
            m_cprev[cp_wa] <= cp_wd;
        end
        cp_rd <= m_cprev[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (fr_we) begin
            m_free[fr_wa] <= fr_wd;
        end
        fr_rd <= m_free[rd_addr];
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_rdaddr <= rd_addr;
        r_cur    <= n_cur;
        r_h      <= n_h;
        r_p      <= n_p;
        r_p2     <= n_p2;
        r_rec    <= n_rec;
        r_hold   <= n_hold;
        if (i_cmd.op == OP_LOAD) begin
            r_key.src   <= i_in_data[31:0];
            r_key.dst   <= i_in_data[63:32];
            r_key.sport <= i_in_data[79:64];
            r_key.dport <= i_in_data[95:80];
            r_key.proto <= i_in_data[103:96];
            r_flags     <= i_in_data[111:104];
            r_len       <= i_in_data[127:112];
            r_now       <= i_in_data[159:128];
        end
        if (emit && out_free) begin
            r_out   <= (i_cmd.op == OP_EMIT_HOLD) ? r_hold : r_rec;
            r_olast <= i_cmd.last;
        end
    end

    // list heads, free list and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rhead    <= '0;
            r_rtail    <= '0;
            r_chead    <= '0;
            r_ctail    <= '0;
            r_rec_head <= '0;
            r_fresh    <= (IW+1)'(1);
            r_act      <= ACT_RESET;
            r_inact    <= INACT_RESET;
            r_ovalid   <= 1'b0;
        end else begin
            r_rhead    <= n_rhead;
            r_rtail    <= n_rtail;
            r_chead    <= n_chead;
            r_ctail    <= n_ctail;
            r_rec_head <= n_rec_head;
            r_fresh    <= n_fresh;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_ACTIVE:   r_act   <= i_cfg_data[ACT_W-1:0];
                    CFG_INACTIVE: r_inact <= i_cfg_data[INACT_W-1:0];
                    default: ;
                endcase
            end
            if (emit && out_free) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_out_rec   = r_out;
    assign o_out_last  = r_olast;

endmodule

### hw/rtl/fct_chk.sv
// ----------------------------------------------------------------------------
// fct_chk
// Port-level checks of the flow cache, bound to the top level.
// ----------------------------------------------------------------------------
module fct_chk (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_s_tvalid,
    input logic                            o_s_tready,
    input logic [fct_pkg::OUT_DATA_W-1:0]  o_m_tdata,
    input logic [2:0]                      o_m_tuser,
    input logic                            o_m_tlast,
    input logic                            o_m_tvalid,
    input logic                            i_m_tready
);
    import fct_pkg::*;

    // one item at a time: no transfer right after another
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("input taken while an item is in work");

    // packet records are always the only record of their item
    a_pkt_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tuser == KIND_HIT || o_m_tuser == KIND_NEW ||
                       o_m_tuser == KIND_DROP) |-> o_m_tlast)
        else $error("packet record without last mark");

    a_drop_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser == KIND_DROP |-> o_m_tdata[239:104] == '0)
        else $error("drop record carries statistics");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("stalled record changed");

endmodule

bind flow_cache_with_timeouts_unit fct_chk u_fct_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser),
    .o_m_tlast  (o_m_tlast),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready)
);
